/* hw/rtl/lss_pkg.sv */
// shared types, constants and the life rule for the streaming life step
// no dependencies; imported by every module of the block
`default_nettype none

package lss_pkg;

	// fixed field widths of the result items
	localparam int ROW_W = 10;
	localparam int COL_W = 5;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 11;
	localparam int ROWS_RAW_W = 11;
	localparam int COLS_RAW_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 8'd1;

	// register values after reset, before clamping to the build limits
	localparam int RESET_ROWS = 20;
	localparam int RESET_COLS = 20;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// one result item
	typedef struct packed {
		logic             alive;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} result_t;

	// one queue entry: one or two results, emitted first then second
	typedef struct packed {
		logic    two;
		result_t first;
		result_t second;
	} entry_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// b3/s23 rule on a 3x3 window; bit 1 of each row is the centre column
	function automatic logic life_next(input logic [2:0] up, input logic [2:0] mid,
		input logic [2:0] low);
		logic [3:0] n;
		n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
			+ 4'(low[0]) + 4'(low[1]) + 4'(low[2]);
		return (n == 4'd3) || ((n == 4'd2) && mid[1]);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/lss_queue.sv */
// short entry queue between the front and the back of the life step
// depends on lss_pkg for the entry and status types
`default_nettype none

module lss_queue
	import lss_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire entry_t        push_entry,
	input  wire logic          pop,
	output entry_t             head,
	output queue_status_t      status
);

	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);

	entry_t         slots_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CNW-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	// status and guarded handshakes
	always_comb begin
		status.full  = (count_q == CNW'(QUEUE_DEPTH));
		status.empty = (count_q == '0);
		do_push      = push && !status.full;
		do_pop       = pop && !status.empty;
		head         = slots_q[rd_ptr_q];
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/lss_front.sv */
// front of the life step: takes cells, keeps the row stores and queues results
// depends on lss_pkg for the result types and the life rule
`default_nettype none

module lss_front
	import lss_pkg::*;
#(
	parameter int MAX_COLS = 32,
	parameter int MAX_ROWS = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cell_valid,
	output logic                                     cell_stall,
	input  wire logic                                cell_alive,
	input  wire logic [$clog2(MAX_ROWS + 1)-1:0]     rows,
	input  wire logic [$clog2(MAX_COLS + 1)-1:0]     cols,
	input  wire logic [MAX_COLS-1:0]                 cols_mask,
	input  wire queue_status_t                       qstat,
	output logic                                     push,
	output entry_t                                   push_entry
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int PADW = MAX_COLS + 2;

	typedef enum logic {
		RUN,
		FLUSH
	} state_t;

	state_t              state_q;
	logic [MAX_COLS-1:0] upper_q;
	logic [MAX_COLS-1:0] middle_q;
	logic [MAX_COLS-1:0] current_q;
	logic [RW-1:0]       row_q;
	logic [CW-1:0]       col_q;
	logic [CW-1:0]       flush_col_q;
	logic [CW-1:0]       flush_last_q;
	logic [RW-1:0]       flush_row_q;

	logic                accept;
	logic [MAX_COLS-1:0] cur_w;
	logic                row_end;
	logic                frame_end;
	logic [PADW-1:0]     up_p;
	logic [PADW-1:0]     mid_p;
	logic [PADW-1:0]     low_p;
	logic [CW-1:0]       idx_a;
	logic [CW-1:0]       idx_b;
	logic                res_a;
	logic                res_b;
	logic                flush_done;

	// input handshake and row/frame boundaries
	always_comb begin
		cell_stall = (state_q == FLUSH) || qstat.full;
		accept     = cell_valid && !cell_stall;
		cur_w        = current_q;
		cur_w[col_q] = cell_alive;
		row_end   = (32'(col_q) + 32'd1) >= 32'(cols);
		frame_end = row_end && ((32'(row_q) + 32'd1) >= 32'(rows));
	end

	// two rule evaluations a cycle: columns c-1 and c, or j and j+1 in the flush
	always_comb begin
		up_p  = {1'b0, upper_q & cols_mask, 1'b0};
		mid_p = {1'b0, middle_q & cols_mask, 1'b0};
		if (state_q == RUN) begin
			low_p = {1'b0, cur_w & cols_mask, 1'b0};
			idx_a = col_q - CW'(1);
			idx_b = col_q;
		end else begin
			low_p = '0;
			idx_a = flush_col_q;
			idx_b = flush_col_q + CW'(1);
		end
		res_a = life_next(up_p[idx_a +: 3], mid_p[idx_a +: 3], low_p[idx_a +: 3]);
		res_b = life_next(up_p[idx_b +: 3], mid_p[idx_b +: 3], low_p[idx_b +: 3]);
	end

	// queue entry for this cycle
	always_comb begin
		push_entry = '0;
		push       = 1'b0;
		flush_done = 1'b0;
		unique case (state_q)
			RUN: begin
				push = accept && (row_q != '0) && ((col_q != '0) || row_end);
				push_entry.two = (col_q != '0) && row_end;
				push_entry.second.alive = res_b;
				push_entry.second.row   = ROW_W'(row_q - RW'(1));
				push_entry.second.col   = COL_W'(col_q);
				push_entry.second.last  = 1'b0;
				if (col_q != '0) begin
					push_entry.first.alive = res_a;
					push_entry.first.col   = COL_W'(idx_a);
				end else begin
					push_entry.first.alive = res_b;
					push_entry.first.col   = COL_W'(col_q);
				end
				push_entry.first.row  = ROW_W'(row_q - RW'(1));
				push_entry.first.last = 1'b0;
			end
			FLUSH: begin
				push = !qstat.full;
				push_entry.two          = (flush_col_q != flush_last_q);
				push_entry.first.alive  = res_a;
				push_entry.first.row    = ROW_W'(flush_row_q);
				push_entry.first.col    = COL_W'(flush_col_q);
				push_entry.first.last   = (flush_col_q == flush_last_q);
				push_entry.second.alive = res_b;
				push_entry.second.row   = ROW_W'(flush_row_q);
				push_entry.second.col   = COL_W'(idx_b);
				push_entry.second.last  = (idx_b == flush_last_q);
				flush_done = push && ((flush_col_q == flush_last_q) || (idx_b == flush_last_q));
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// state, row stores and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= RUN;
			upper_q      <= '0;
			middle_q     <= '0;
			current_q    <= '0;
			row_q        <= '0;
			col_q        <= '0;
			flush_col_q  <= '0;
			flush_last_q <= '0;
			flush_row_q  <= '0;
		end else begin
			unique case (state_q)
				RUN: begin
					if (accept) begin
						if (row_end) begin
							upper_q   <= middle_q;
							middle_q  <= cur_w;
							current_q <= '0;
						end else begin
							current_q <= cur_w;
						end
						if (frame_end) begin
							// last row still to emit against a dead row below
							state_q      <= FLUSH;
							flush_col_q  <= '0;
							flush_last_q <= col_q;
							flush_row_q  <= row_q;
							row_q        <= '0;
							col_q        <= '0;
						end else if (row_end) begin
							row_q <= row_q + RW'(1);
							col_q <= '0;
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
				end
				FLUSH: begin
					if (flush_done) begin
						// new frame starts with empty stores
						state_q   <= RUN;
						upper_q   <= '0;
						middle_q  <= '0;
						current_q <= '0;
					end else if (push) begin
						flush_col_q <= flush_col_q + CW'(2);
					end
				end
				default: begin
					state_q <= RUN;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/lss_back.sv */
// back of the life step: drains queue entries into the result register
// depends on lss_pkg for the entry and status types
`default_nettype none

module lss_back
	import lss_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire entry_t        head,
	input  wire queue_status_t qstat,
	output logic               pop,
	output logic               res_valid,
	input  wire logic          res_stall,
	output logic               next_alive,
	output logic [ROW_W-1:0]   out_row,
	output logic [COL_W-1:0]   out_col,
	output logic               frame_last
);

	logic             res_valid_q;
	logic             slot_q;
	logic             next_alive_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             frame_last_q;
	logic             load;
	result_t          pick;

	// pick the next result of the head entry
	always_comb begin
		load = (!res_valid_q || !res_stall) && !qstat.empty;
		pick = slot_q ? head.second : head.first;
		pop  = load && (slot_q || !head.two);
	end

	// output valid and slot index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			slot_q      <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				slot_q      <= !pop;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			next_alive_q <= pick.alive;
			out_row_q    <= pick.row;
			out_col_q    <= pick.col;
			frame_last_q <= pick.last;
		end
	end

	assign res_valid  = res_valid_q;
	assign next_alive = next_alive_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign frame_last = frame_last_q;

endmodule

`default_nettype wire

/* hw/rtl/life_automaton_stream_step.sv */
// top level of the streaming life step: configuration registers and the three parts
// depends on lss_pkg, lss_front, lss_queue and lss_back
`default_nettype none

// One generation of Life (born on 3, survives on 2 or 3) over a bounded grid whose
// edges are dead. Cells enter one per cycle in raster order while cell_stall is
// low; the next state of a cell is queued once the cell below and to its right has
// arrived (the cell below, at the end of a row); results leave one per cycle
// from the output register while res_stall is low, and the frame's final cell also
// releases the whole last row, the very last result carrying frame_last. The front
// takes one cell every cycle while the queue is not full; after the final cell of
// a frame it holds off new cells while it queues the last row two results a cycle
// while the queue has room, the single result port draining them. The result port
// carries rows x cols results a frame and keeps pace with the input. A four-entry
// queue separates the front from the result register, so the two sides stall
// independently. Configuration writes are always ready and are meant for idle time.
module life_automaton_stream_step
	import lss_pkg::*;
#(
	parameter int MAX_COLS = 32,
	parameter int MAX_ROWS = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cell_valid,
	output logic                       cell_stall,
	input  wire logic                  cell_alive,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic                       next_alive,
	output logic [ROW_W-1:0]           out_row,
	output logic [COL_W-1:0]           out_col,
	output logic                       frame_last,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int RST_ROWS = (RESET_ROWS > MAX_ROWS) ? MAX_ROWS : RESET_ROWS;
	localparam int RST_COLS = (RESET_COLS > MAX_COLS) ? MAX_COLS : RESET_COLS;
	localparam logic [MAX_COLS-1:0] RST_MASK = ~({MAX_COLS{1'b1}} << RST_COLS);

	logic [RNW-1:0]        rows_q;
	logic [CNW-1:0]        cols_q;
	logic [MAX_COLS-1:0]   cols_mask_q;
	logic [ROWS_RAW_W-1:0] rows_raw;
	logic [COLS_RAW_W-1:0] cols_raw;
	logic [RNW-1:0]        rows_clamp;
	logic [CNW-1:0]        cols_clamp;
	logic                  cfg_write;

	logic                  push;
	entry_t                push_entry;
	logic                  pop;
	entry_t                head;
	queue_status_t         qstat;

	// clamp written values into the supported range
	always_comb begin
		cfg_ready = 1'b1;
		cfg_write = cfg_valid && cfg_ready;
		rows_raw  = cfg_data[ROWS_RAW_W-1:0];
		cols_raw  = cfg_data[COLS_RAW_W-1:0];
		priority if (rows_raw < ROWS_RAW_W'(2)) begin
			rows_clamp = RNW'(2);
		end else if (32'(rows_raw) > MAX_ROWS) begin
			rows_clamp = RNW'(MAX_ROWS);
		end else begin
			rows_clamp = RNW'(rows_raw);
		end
		priority if (cols_raw < COLS_RAW_W'(2)) begin
			cols_clamp = CNW'(2);
		end else if (32'(cols_raw) > MAX_COLS) begin
			cols_clamp = CNW'(MAX_COLS);
		end else begin
			cols_clamp = CNW'(cols_raw);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= RNW'(RST_ROWS);
			cols_q      <= CNW'(RST_COLS);
			cols_mask_q <= RST_MASK;
		end else if (cfg_write) begin
			if (cfg_index == REG_ROWS) begin
				rows_q <= rows_clamp;
			end else if (cfg_index == REG_COLS) begin
				cols_q      <= cols_clamp;
				cols_mask_q <= ~({MAX_COLS{1'b1}} << cols_clamp);
			end
		end
	end

	lss_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_alive (cell_alive),
		.rows       (rows_q),
		.cols       (cols_q),
		.cols_mask  (cols_mask_q),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	lss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (qstat)
	);

	lss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.next_alive (next_alive),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last)
	);

endmodule

`default_nettype wire
